// ----- src/multilevel_waveform_peak_decimator_core_macros.svh -----
// Assertion helpers for the peak decimator checker.
`ifndef MULTILEVEL_WAVEFORM_PEAK_DECIMATOR_CORE_MACROS_SVH
`define MULTILEVEL_WAVEFORM_PEAK_DECIMATOR_CORE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define MWPD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mwpd same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define MWPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mwpd next-cycle check failed");

`endif

// ----- src/mwpd_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package mwpd_pkg;

    localparam int NUM_LEVELS       = 4;
    localparam int MAX_CHANNELS     = 8;
    localparam int BASE_BLOCK_SHIFT = 8;
    localparam int LEVEL_STEP_SHIFT = 2;
    localparam int FRAME_COUNT_BITS = 32;

    localparam int SAMPLE_W        = 16;
    localparam int PEAK_INDEX_W    = 24;
    localparam int LEVEL_FIELD_W   = 2;
    localparam int CHANNEL_FIELD_W = 3;
    localparam int CFG_W           = 4;
    localparam int S_TDATA_W       = 16;
    localparam int M_TDATA_W       = 56;
    localparam int M_TUSER_W       = 6;

    localparam int SLOT_COUNT = NUM_LEVELS * MAX_CHANNELS;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int LEVEL_W    = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int CHAN_W     = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int NCH_W      = $clog2(MAX_CHANNELS + 1);

    localparam logic [CFG_W-1:0] RESET_CHANNELS = 4'd2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    localparam sample_t Q15_POS_ONE = 16'sh7FFF;
    localparam sample_t Q15_NEG_ONE = 16'sh8000;

    typedef struct packed {
        sample_t min_v;
        sample_t max_v;
    } peak_pair_t;

    localparam peak_pair_t PAIR_RESET = '{min_v: Q15_POS_ONE, max_v: Q15_NEG_ONE};

    typedef struct packed {
        logic              rd_en;
        logic [SLOT_W-1:0] rd_addr;
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        peak_pair_t        wr_data;
        logic              clr_all;
    } store_req_t;

    typedef struct packed {
        logic [LEVEL_FIELD_W-1:0]   level;
        logic [PEAK_INDEX_W-1:0]    peak_index;
        logic [CHANNEL_FIELD_W-1:0] channel;
        sample_t                    min_value;
        sample_t                    max_value;
        logic                       count_overflow;
        logic                       last;
    } result_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPD_RD,
        ST_UPD_WR,
        ST_EMIT_RD,
        ST_EMIT_LD
    } seq_state_t;

    function automatic int level_shift(input int lvl);
        return BASE_BLOCK_SHIFT + lvl * LEVEL_STEP_SHIFT;
    endfunction

    function automatic logic [SLOT_W-1:0] slot_addr(input logic [LEVEL_W-1:0] lvl,
                                                   input logic [CHAN_W-1:0] ch);
        return SLOT_W'(int'(lvl) * MAX_CHANNELS + int'(ch));
    endfunction

    // One bit per level: the frame at this count is the last of a block.
    function automatic logic [NUM_LEVELS-1:0] block_closes(
        input logic [FRAME_COUNT_BITS-1:0] count);
        logic [NUM_LEVELS-1:0]       closes;
        logic [FRAME_COUNT_BITS-1:0] m;
        closes = '0;
        for (int l = 0; l < NUM_LEVELS; l++) begin
            m = FRAME_COUNT_BITS'((64'd1 << level_shift(l)) - 64'd1);
            closes[l] = ((count & m) == m);
        end
        return closes;
    endfunction

    function automatic logic [PEAK_INDEX_W-1:0] peak_index_of(
        input logic [LEVEL_W-1:0] lvl, input logic [FRAME_COUNT_BITS-1:0] count);
        logic [FRAME_COUNT_BITS+PEAK_INDEX_W-1:0] ext;
        ext = '0;
        for (int l = 0; l < NUM_LEVELS; l++) begin
            if (l == int'(lvl)) begin
                ext = {{PEAK_INDEX_W{1'b0}}, count} >> level_shift(l);
            end
        end
        return ext[PEAK_INDEX_W-1:0];
    endfunction

    function automatic logic [LEVEL_W-1:0] first_set(input logic [NUM_LEVELS-1:0] mask);
        logic [LEVEL_W-1:0] r;
        r = '0;
        for (int l = NUM_LEVELS - 1; l >= 0; l--) begin
            if (mask[l]) begin
                r = LEVEL_W'(l);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/mwpd_minmax_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mwpd_minmax_unit
    import mwpd_pkg::*;
(
    input  wire sample_t    sample,
    input  wire peak_pair_t cur,
    output peak_pair_t      upd
);

    always_comb
    begin
        upd.min_v = (sample < cur.min_v) ? sample : cur.min_v;
        upd.max_v = (sample > cur.max_v) ? sample : cur.max_v;
    end

endmodule

`default_nettype wire

// ----- src/mwpd_slot_store.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mwpd_slot_store
    import mwpd_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire store_req_t req,
    output peak_pair_t      rd_pair
);

    peak_pair_t            pair_mem_reg [SLOT_COUNT];
    peak_pair_t            rd_data_reg;
    logic [SLOT_COUNT-1:0] valid_reg;
    logic                  rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            pair_mem_reg[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= pair_mem_reg[req.rd_addr];
        end
    end

    // An entry not written since reset or end of stream reads as the reset pair.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.clr_all)
            begin
                valid_reg <= '0;
            end
            else if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_pair = rd_valid_reg ? rd_data_reg : PAIR_RESET;

endmodule

`default_nettype wire

// ----- src/mwpd_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module mwpd_seq
    import mwpd_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire sample_t          in_sample,
    input  wire logic             in_eos,
    input  wire logic             cfg_valid,
    input  wire logic [CFG_W-1:0] cfg_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output result_t               out_item,
    output store_req_t            req,
    input  wire peak_pair_t       rd_pair
);

    seq_state_t                  state_reg, state_next;
    logic [LEVEL_W-1:0]          lvl_reg, lvl_next;
    logic [CHAN_W-1:0]           chan_reg, chan_next;
    logic [CFG_W-1:0]            nch_cfg_reg, nch_cfg_next;
    logic [CHAN_W-1:0]           pos_reg, pos_next;
    logic [FRAME_COUNT_BITS-1:0] frame_count_reg, frame_count_next;
    logic                        wrapped_reg, wrapped_next;
    logic [NUM_LEVELS-1:0]       emit_mask_reg, emit_mask_next;
    logic                        eos_reg, eos_next;
    logic                        ovf_reg, ovf_next;
    logic                        out_valid_reg, out_valid_next;
    sample_t                     sample_reg, sample_next;
    logic [CHAN_W-1:0]           item_ch_reg, item_ch_next;
    logic [FRAME_COUNT_BITS-1:0] old_count_reg, old_count_next;
    result_t                     out_item_reg, out_item_next;

    logic [NCH_W-1:0]            nch;
    logic                        frame_close;
    logic [FRAME_COUNT_BITS-1:0] count_inc;
    logic                        wrap_now;
    logic [LEVEL_W-1:0]          cur_lvl;
    logic [NUM_LEVELS-1:0]       mask_rest;
    logic                        chan_last;
    logic                        item_last;
    peak_pair_t                  upd_pair;

    mwpd_minmax_unit u_minmax (
        .sample (sample_reg),
        .cur    (rd_pair),
        .upd    (upd_pair)
    );

    always_comb
    begin
        if (nch_cfg_reg == '0)
        begin
            nch = NCH_W'(1);
        end
        else if (int'(nch_cfg_reg) > MAX_CHANNELS)
        begin
            nch = NCH_W'(MAX_CHANNELS);
        end
        else
        begin
            nch = NCH_W'(nch_cfg_reg);
        end
    end

    assign frame_close = (int'(pos_reg) + 1 >= int'(nch));
    assign count_inc   = frame_count_reg + FRAME_COUNT_BITS'(1);
    assign wrap_now    = (count_inc == '0);
    assign cur_lvl     = first_set(emit_mask_reg);
    assign chan_last   = (int'(chan_reg) + 1 >= int'(nch));

    always_comb
    begin
        mask_rest          = emit_mask_reg;
        mask_rest[cur_lvl] = 1'b0;
    end

    assign item_last = chan_last && (mask_rest == '0);

    always_comb
    begin
        state_next       = state_reg;
        lvl_next         = lvl_reg;
        chan_next        = chan_reg;
        nch_cfg_next     = nch_cfg_reg;
        pos_next         = pos_reg;
        frame_count_next = frame_count_reg;
        wrapped_next     = wrapped_reg;
        emit_mask_next   = emit_mask_reg;
        eos_next         = eos_reg;
        ovf_next         = ovf_reg;
        sample_next      = sample_reg;
        item_ch_next     = item_ch_reg;
        old_count_next   = old_count_reg;
        out_item_next    = out_item_reg;
        out_valid_next   = out_valid_reg && !out_ready;
        req              = '0;
        in_ready         = 1'b0;

        if (cfg_valid)
        begin
            nch_cfg_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    sample_next    = in_sample;
                    item_ch_next   = pos_reg;
                    old_count_next = frame_count_reg;
                    lvl_next       = '0;
                    state_next     = ST_UPD_RD;
                    if (frame_close)
                    begin
                        pos_next       = '0;
                        eos_next       = in_eos;
                        ovf_next       = wrapped_reg || wrap_now;
                        emit_mask_next = block_closes(frame_count_reg)
                                         | {NUM_LEVELS{in_eos}};
                        if (in_eos)
                        begin
                            frame_count_next = '0;
                            wrapped_next     = 1'b0;
                        end
                        else
                        begin
                            frame_count_next = count_inc;
                            wrapped_next     = wrapped_reg || wrap_now;
                        end
                    end
                    else
                    begin
                        pos_next       = pos_reg + CHAN_W'(1);
                        eos_next       = 1'b0;
                        emit_mask_next = '0;
                    end
                end
            end

            ST_UPD_RD:
            begin
                req.rd_en   = 1'b1;
                req.rd_addr = slot_addr(lvl_reg, item_ch_reg);
                state_next  = ST_UPD_WR;
            end

            ST_UPD_WR:
            begin
                req.wr_en   = 1'b1;
                req.wr_addr = slot_addr(lvl_reg, item_ch_reg);
                req.wr_data = upd_pair;
                if (int'(lvl_reg) == NUM_LEVELS - 1)
                begin
                    chan_next  = '0;
                    state_next = (emit_mask_reg != '0) ? ST_EMIT_RD : ST_IDLE;
                end
                else
                begin
                    lvl_next   = lvl_reg + LEVEL_W'(1);
                    state_next = ST_UPD_RD;
                end
            end

            ST_EMIT_RD:
            begin
                req.rd_en   = 1'b1;
                req.rd_addr = slot_addr(cur_lvl, chan_reg);
                state_next  = ST_EMIT_LD;
            end

            ST_EMIT_LD:
            begin
                // read data holds here until the output register frees up
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next               = 1'b1;
                    out_item_next.level          = LEVEL_FIELD_W'(cur_lvl);
                    out_item_next.peak_index     = peak_index_of(cur_lvl, old_count_reg);
                    out_item_next.channel        = CHANNEL_FIELD_W'(chan_reg);
                    out_item_next.min_value      = rd_pair.min_v;
                    out_item_next.max_value      = rd_pair.max_v;
                    out_item_next.count_overflow = ovf_reg;
                    out_item_next.last           = item_last;
                    req.wr_en                    = 1'b1;
                    req.wr_addr                  = slot_addr(cur_lvl, chan_reg);
                    req.wr_data                  = PAIR_RESET;
                    if (chan_last)
                    begin
                        emit_mask_next = mask_rest;
                        chan_next      = '0;
                        if (mask_rest == '0)
                        begin
                            req.clr_all = eos_reg;
                            state_next  = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_EMIT_RD;
                        end
                    end
                    else
                    begin
                        chan_next  = chan_reg + CHAN_W'(1);
                        state_next = ST_EMIT_RD;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            lvl_reg         <= '0;
            chan_reg        <= '0;
            nch_cfg_reg     <= RESET_CHANNELS;
            pos_reg         <= '0;
            frame_count_reg <= '0;
            wrapped_reg     <= 1'b0;
            emit_mask_reg   <= '0;
            eos_reg         <= 1'b0;
            ovf_reg         <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            lvl_reg         <= lvl_next;
            chan_reg        <= chan_next;
            nch_cfg_reg     <= nch_cfg_next;
            pos_reg         <= pos_next;
            frame_count_reg <= frame_count_next;
            wrapped_reg     <= wrapped_next;
            emit_mask_reg   <= emit_mask_next;
            eos_reg         <= eos_next;
            ovf_reg         <= ovf_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg    <= sample_next;
        item_ch_reg   <= item_ch_next;
        old_count_reg <= old_count_next;
        out_item_reg  <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

`default_nettype wire

// ----- src/multilevel_waveform_peak_decimator_core.sv -----
// Sequence: an item is taken in the idle state, then each level updates its running
// min/max by a slot read and a slot write, for each of the 4 levels in turn.
// Each peak then takes a slot read and an output load, and the load waits while the
// output stalls. A new item is taken only back in idle; the core is not ready meanwhile.
// Reset: num_channels = 2, counters cleared, slot valid bits cleared at once (no sweep).
`timescale 1ns / 1ps
`default_nettype none

module multilevel_waveform_peak_decimator_core
    import mwpd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // [15:0] sample
    input  wire logic                 s_tlast,   // end_of_stream
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [M_TDATA_W-1:0]      m_tdata,   // [23:0] peak_index, [39:24] min, [55:40] max
    output logic [M_TUSER_W-1:0]      m_tuser,   // [1:0] level, [4:2] channel, [5] overflow
    output logic                      m_tlast,   // last
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_W-1:0]     cfg_data   // num_channels
);

    store_req_t req;
    peak_pair_t rd_pair;
    result_t    out_item;

    mwpd_slot_store u_store (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rd_pair (rd_pair)
    );

    mwpd_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_sample (sample_t'(s_tdata[SAMPLE_W-1:0])),
        .in_eos    (s_tlast),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item),
        .req       (req),
        .rd_pair   (rd_pair)
    );

    assign cfg_ready = 1'b1;
    assign m_tdata   = {out_item.max_value, out_item.min_value, out_item.peak_index};
    assign m_tuser   = {out_item.count_overflow, out_item.channel, out_item.level};
    assign m_tlast   = out_item.last;

endmodule

`default_nettype wire

// ----- src/mwpd_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "multilevel_waveform_peak_decimator_core_macros.svh"

module mwpd_checker
    import mwpd_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [M_TUSER_W-1:0] m_tuser,
    input wire logic                 m_tlast
);

    logic [M_TDATA_W+M_TUSER_W:0] m_bundle;

    assign m_bundle = {m_tlast, m_tuser, m_tdata};

    `MWPD_ASSERT_NEXT(a_out_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid)
    `MWPD_ASSERT_NEXT(a_out_stable, clk, rst_n, m_tvalid && !m_tready, $stable(m_bundle))
    // an accepted item always leaves the sequencer busy in the following cycle
    `MWPD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)
    // while a burst is only partly out, no new item may be taken
    `MWPD_ASSERT_SAME(a_busy_mid_burst, clk, rst_n, m_tvalid && !m_tlast, !s_tready)

endmodule

bind multilevel_waveform_peak_decimator_core mwpd_checker u_mwpd_checker (.*);

`default_nettype wire
